// ===== rtl/core/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

  localparam int HEAP_UNITS_DEF   = 4096;
  localparam int HEADER_UNITS_DEF = 3;
  localparam int SPLIT_SLACK_DEF  = 2;

  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int BYTES_W = 24;
  localparam int CFG_W   = 13;
  localparam int ST_W    = 2;
  localparam int CU_W    = 13;
  localparam int FB_W    = 17;
  localparam int NEED_W  = 21;

  localparam logic [CFG_W-1:0] HEAP_UNITS_RST = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INIT   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_OOM     = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
  localparam logic [ST_W-1:0] ST_SMALL   = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
`default_nettype none
// First-fit heap manager with coalescing. Raise start while busy is low to hand over one
// command beat; busy stays high until the answer, which appears for exactly one cycle with
// out_valid and cannot be held off. Block headers live in a synchronous table with a registered
// read, so an allocate visits the blocks one at a time, a free merges the block with a free
// neighbour on either side, and a moving resize does both. After reset, and on every successful
// initialize, all HEAP_UNITS table entries are swept clear at one entry a cycle, with busy high.
module first_fit_heap_allocator #(
  parameter int HEAP_UNITS        = ffha_pkg::HEAP_UNITS_DEF,
  parameter int HEADER_UNITS      = ffha_pkg::HEADER_UNITS_DEF,
  parameter int SPLIT_SLACK_UNITS = ffha_pkg::SPLIT_SLACK_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ffha_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [ffha_pkg::ADDR_W-1:0]    in_address,
  input  wire logic [ffha_pkg::BYTES_W-1:0]   in_request_bytes,
  output logic                                out_valid,
  output logic      [ffha_pkg::ST_W-1:0]      out_status,
  output logic      [ffha_pkg::ADDR_W-1:0]    out_result_address,
  output logic      [ffha_pkg::ADDR_W-1:0]    out_copy_from,
  output logic      [ffha_pkg::CU_W-1:0]      out_copy_units,
  output logic      [ffha_pkg::FB_W-1:0]      out_free_bytes,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ffha_pkg::CFG_W-1:0]     cfg_heap_units
);

  localparam int UW = $clog2(HEAP_UNITS + 1);
  localparam int AW = $clog2(HEAP_UNITS);
  localparam int NW = ffha_pkg::NEED_W;
  localparam int CW = ((UW > NW) ? UW : NW) + 2;
  localparam int FW = ffha_pkg::FB_W;
  localparam int MW = UW + 2;
  localparam int PW = AW + 1;
  localparam logic [UW-1:0] HDR = UW'(HEADER_UNITS);
  localparam logic [CW-1:0] HDR_C = CW'(HEADER_UNITS);
  localparam logic [CW-1:0] SLACK_C = CW'(SPLIT_SLACK_UNITS);
  localparam logic [FW-1:0] HDR_BYTES = FW'(HEADER_UNITS * 16);
  localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_UNITS - 1);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_IDLE  = 5'd2;
  localparam logic [4:0] S_AL_RD = 5'd3;
  localparam logic [4:0] S_AL_CK = 5'd4;
  localparam logic [4:0] S_FU_CK = 5'd5;
  localparam logic [4:0] S_RG_CK = 5'd6;
  localparam logic [4:0] S_SP0   = 5'd7;
  localparam logic [4:0] S_SP1   = 5'd8;
  localparam logic [4:0] S_POST  = 5'd9;
  localparam logic [4:0] S_FR_RD = 5'd10;
  localparam logic [4:0] S_FR_LD = 5'd11;
  localparam logic [4:0] S_M0    = 5'd12;
  localparam logic [4:0] S_M1    = 5'd13;
  localparam logic [4:0] S_M2    = 5'd14;
  localparam logic [4:0] S_FP    = 5'd15;
  localparam logic [4:0] S_FP1   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  function automatic logic [FW-1:0] x16(input logic [CW-1:0] v);
    x16 = FW'({v, 4'b0000});
  endfunction

  logic [4:0] state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic init_r, init_nxt;
  logic ready_r, ready_nxt;
  logic [UW-1:0] end_r, end_nxt;
  logic [UW-1:0] pend_r, pend_nxt;
  logic [FW-1:0] fbc_r, fbc_nxt;
  logic [ffha_pkg::CFG_W-1:0] hu_r;
  logic [ffha_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [ffha_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [NW-1:0] need_r, need_nxt;
  logic zb_r, zb_nxt;
  logic [UW-1:0] h_r, h_nxt;
  logic [UW-1:0] b_r, b_nxt;
  logic [UW-1:0] sz_r, sz_nxt;
  logic [UW-1:0] old_r, old_nxt;
  logic [UW-1:0] m_r, m_nxt;
  logic [UW-1:0] ms_r, ms_nxt;
  logic pvh_r, pvh_nxt;
  logic [AW-1:0] pvp_r, pvp_nxt;
  logic mp_r, mp_nxt;
  logic mv_r, mv_nxt;
  logic rsz_r, rsz_nxt;
  logic [ffha_pkg::ST_W-1:0] st_r, st_nxt;
  logic [ffha_pkg::ADDR_W-1:0] res_r, res_nxt;
  logic [ffha_pkg::ADDR_W-1:0] cf_r, cf_nxt;
  logic [ffha_pkg::CU_W-1:0] cu_r, cu_nxt;

  logic mw_en, pw_en, r_en;
  logic [AW-1:0] mw_addr, pw_addr, r_addr;
  logic [MW-1:0] mw_data, m_rd;
  logic [PW-1:0] pw_data, p_rd;

  logic rd_hdr, rd_fre;
  logic [UW-1:0] rd_size;
  logic acc;
  logic [UW-1:0] end_c;
  logic [ffha_pkg::BYTES_W:0] bytes_r1;
  logic [NW-1:0] need_c;
  logic [CW-1:0] hx_c;
  logic [UW-1:0] walk_nx, blk_n, tsplit, sp_n, m_n, m_nn, rg_nn;
  logic do_split;

  assign rd_hdr  = m_rd[UW+1];
  assign rd_fre  = m_rd[UW];
  assign rd_size = m_rd[UW-1:0];

  assign acc = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign end_c = (CW'(hu_r) > CW'(HEAP_UNITS)) ? UW'(HEAP_UNITS) : UW'(hu_r);
  assign bytes_r1 = (in_request_bytes == '0) ? (ffha_pkg::BYTES_W+1)'(1)
                                             : (ffha_pkg::BYTES_W+1)'(in_request_bytes);
  assign need_c = NW'((bytes_r1 + (ffha_pkg::BYTES_W+1)'(15)) >> 4);
  assign hx_c = CW'(in_address) - HDR_C;

  assign walk_nx  = h_r + HDR + rd_size;
  assign blk_n    = b_r + HDR + old_r;
  assign tsplit   = h_r + HDR + UW'(need_r);
  assign sp_n     = h_r + HDR + sz_r;
  assign m_n      = m_r + HDR + ms_r;
  assign m_nn     = m_n + HDR + rd_size;
  assign rg_nn    = blk_n + HDR + rd_size;
  assign do_split = CW'(sz_r) >= CW'(need_r) + HDR_C + SLACK_C;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    init_nxt = init_r;
    ready_nxt = ready_r;
    end_nxt = end_r;
    pend_nxt = pend_r;
    fbc_nxt = fbc_r;
    mode_nxt = mode_r;
    addr_nxt = addr_r;
    need_nxt = need_r;
    zb_nxt = zb_r;
    h_nxt = h_r;
    b_nxt = b_r;
    sz_nxt = sz_r;
    old_nxt = old_r;
    m_nxt = m_r;
    ms_nxt = ms_r;
    pvh_nxt = pvh_r;
    pvp_nxt = pvp_r;
    mp_nxt = mp_r;
    mv_nxt = mv_r;
    rsz_nxt = rsz_r;
    st_nxt = st_r;
    res_nxt = res_r;
    cf_nxt = cf_r;
    cu_nxt = cu_r;
    mw_en = 1'b0;
    mw_addr = '0;
    mw_data = '0;
    pw_en = 1'b0;
    pw_addr = '0;
    pw_data = '0;
    r_en = 1'b0;
    r_addr = '0;

    case (state_r)
      S_CLR: begin
        mw_en = 1'b1;
        mw_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = init_r ? S_INIT : S_IDLE;
        end
      end
      S_INIT: begin
        mw_en = 1'b1;
        mw_data = {1'b1, 1'b1, pend_r - HDR};
        pw_en = 1'b1;
        fbc_nxt = x16(CW'(pend_r - HDR));
        ready_nxt = 1'b1;
        end_nxt = pend_r;
        init_nxt = 1'b0;
        state_nxt = S_DONE;
      end
      S_IDLE: begin
        if (acc) begin
          st_nxt = ffha_pkg::ST_OK;
          res_nxt = '0;
          cf_nxt = '0;
          cu_nxt = '0;
          mode_nxt = in_mode;
          addr_nxt = in_address;
          need_nxt = need_c;
          zb_nxt = (in_request_bytes == '0);
          mv_nxt = 1'b0;
          rsz_nxt = 1'b0;
          h_nxt = '0;
          if (in_mode == ffha_pkg::MODE_INIT) begin
            if (CW'(end_c) <= HDR_C) begin
              st_nxt = ffha_pkg::ST_SMALL;
              state_nxt = S_DONE;
            end else begin
              pend_nxt = end_c;
              init_nxt = 1'b1;
              clr_nxt = '0;
              state_nxt = S_CLR;
            end
          end else if (in_mode == ffha_pkg::MODE_ALLOC ||
                       (in_mode == ffha_pkg::MODE_RESIZE && in_address == '0)) begin
            if (!ready_r) begin
              st_nxt = ffha_pkg::ST_OOM;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_AL_RD;
            end
          end else if (in_mode == ffha_pkg::MODE_FREE && in_address == '0) begin
            state_nxt = S_DONE;
          end else begin
            if (!ready_r || CW'(in_address) < HDR_C || hx_c >= CW'(end_r)) begin
              st_nxt = ffha_pkg::ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              r_en = 1'b1;
              r_addr = hx_c[AW-1:0];
              b_nxt = UW'(hx_c);
              state_nxt = S_FU_CK;
            end
          end
        end
      end
      S_AL_RD: begin
        if (h_r < end_r) begin
          r_en = 1'b1;
          r_addr = h_r[AW-1:0];
          state_nxt = S_AL_CK;
        end else begin
          st_nxt = ffha_pkg::ST_OOM;
          state_nxt = S_DONE;
        end
      end
      S_AL_CK: begin
        if (rd_fre && CW'(rd_size) >= CW'(need_r)) begin
          sz_nxt = rd_size;
          res_nxt = ffha_pkg::ADDR_W'(h_r + HDR);
          state_nxt = S_SP0;
        end else if (walk_nx < end_r) begin
          r_en = 1'b1;
          r_addr = walk_nx[AW-1:0];
          h_nxt = walk_nx;
        end else begin
          st_nxt = ffha_pkg::ST_OOM;
          state_nxt = S_DONE;
        end
      end
      S_FU_CK: begin
        old_nxt = rd_size;
        if (!rd_hdr || rd_fre) begin
          st_nxt = ffha_pkg::ST_INVALID;
          state_nxt = S_DONE;
        end else if (mode_r == ffha_pkg::MODE_FREE || zb_r) begin
          state_nxt = S_FR_LD;
        end else if (CW'(rd_size) >= CW'(need_r)) begin
          h_nxt = b_r;
          sz_nxt = rd_size;
          rsz_nxt = 1'b1;
          res_nxt = addr_r;
          state_nxt = S_SP0;
        end else if ((b_r + HDR + rd_size) < end_r) begin
          r_en = 1'b1;
          r_addr = AW'(b_r + HDR + rd_size);
          state_nxt = S_RG_CK;
        end else begin
          mv_nxt = 1'b1;
          h_nxt = '0;
          state_nxt = S_AL_RD;
        end
      end
      S_RG_CK: begin
        if (rd_fre && CW'(old_r) + HDR_C + CW'(rd_size) >= CW'(need_r)) begin
          fbc_nxt = fbc_r - x16(CW'(rd_size));
          mw_en = 1'b1;
          mw_addr = blk_n[AW-1:0];
          if (rg_nn < end_r) begin
            pw_en = 1'b1;
            pw_addr = rg_nn[AW-1:0];
            pw_data = {1'b1, b_r[AW-1:0]};
          end
          h_nxt = b_r;
          sz_nxt = old_r + HDR + rd_size;
          rsz_nxt = 1'b1;
          res_nxt = addr_r;
          state_nxt = S_SP0;
        end else begin
          mv_nxt = 1'b1;
          h_nxt = '0;
          state_nxt = S_AL_RD;
        end
      end
      S_SP0: begin
        mw_en = 1'b1;
        if (do_split) begin
          mw_addr = tsplit[AW-1:0];
          mw_data = {1'b1, 1'b1, sz_r - UW'(need_r) - HDR};
          pw_en = 1'b1;
          pw_addr = tsplit[AW-1:0];
          pw_data = {1'b1, h_r[AW-1:0]};
          if (rsz_r) begin
            fbc_nxt = fbc_r + x16(CW'(sz_r) - CW'(need_r)) - HDR_BYTES;
          end else begin
            fbc_nxt = fbc_r - HDR_BYTES - x16(CW'(need_r));
          end
          state_nxt = S_SP1;
        end else begin
          mw_addr = h_r[AW-1:0];
          mw_data = {1'b1, 1'b0, sz_r};
          if (!rsz_r) begin
            fbc_nxt = fbc_r - x16(CW'(sz_r));
          end
          state_nxt = S_POST;
        end
      end
      S_SP1: begin
        mw_en = 1'b1;
        mw_addr = h_r[AW-1:0];
        mw_data = {1'b1, 1'b0, UW'(need_r)};
        if (sp_n < end_r) begin
          pw_en = 1'b1;
          pw_addr = sp_n[AW-1:0];
          pw_data = {1'b1, tsplit[AW-1:0]};
        end
        state_nxt = S_POST;
      end
      S_POST: begin
        if (mv_r) begin
          cf_nxt = addr_r;
          cu_nxt = ffha_pkg::CU_W'(old_r);
          state_nxt = S_FR_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FR_RD: begin
        r_en = 1'b1;
        r_addr = b_r[AW-1:0];
        state_nxt = S_FR_LD;
      end
      S_FR_LD: begin
        fbc_nxt = fbc_r + x16(CW'(rd_size));
        m_nxt = b_r;
        ms_nxt = rd_size;
        pvh_nxt = p_rd[AW];
        pvp_nxt = p_rd[AW-1:0];
        mp_nxt = 1'b0;
        state_nxt = S_M0;
      end
      S_M0: begin
        if (m_n < end_r) begin
          r_en = 1'b1;
          r_addr = m_n[AW-1:0];
          state_nxt = S_M1;
        end else begin
          state_nxt = S_M2;
        end
      end
      S_M1: begin
        if (rd_fre) begin
          mw_en = 1'b1;
          mw_addr = m_n[AW-1:0];
          if (m_nn < end_r) begin
            pw_en = 1'b1;
            pw_addr = m_nn[AW-1:0];
            pw_data = {1'b1, m_r[AW-1:0]};
          end
          fbc_nxt = fbc_r + HDR_BYTES;
          ms_nxt = ms_r + HDR + rd_size;
        end
        state_nxt = S_M2;
      end
      S_M2: begin
        mw_en = 1'b1;
        mw_addr = m_r[AW-1:0];
        mw_data = {1'b1, 1'b1, ms_r};
        state_nxt = mp_r ? S_DONE : S_FP;
      end
      S_FP: begin
        if (pvh_r && CW'(pvp_r) < CW'(end_r)) begin
          r_en = 1'b1;
          r_addr = pvp_r;
          state_nxt = S_FP1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FP1: begin
        if (rd_hdr && rd_fre) begin
          m_nxt = UW'(pvp_r);
          ms_nxt = rd_size;
          mp_nxt = 1'b1;
          state_nxt = S_M0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      init_r <= 1'b0;
      ready_r <= 1'b0;
      end_r <= '0;
      fbc_r <= '0;
      hu_r <= ffha_pkg::HEAP_UNITS_RST;
      mv_r <= 1'b0;
      rsz_r <= 1'b0;
      mp_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      init_r <= init_nxt;
      ready_r <= ready_nxt;
      end_r <= end_nxt;
      fbc_r <= fbc_nxt;
      mv_r <= mv_nxt;
      rsz_r <= rsz_nxt;
      mp_r <= mp_nxt;
      if (cfg_valid && cfg_ready) begin
        hu_r <= cfg_heap_units;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    mode_r <= mode_nxt;
    addr_r <= addr_nxt;
    need_r <= need_nxt;
    zb_r <= zb_nxt;
    h_r <= h_nxt;
    b_r <= b_nxt;
    sz_r <= sz_nxt;
    old_r <= old_nxt;
    m_r <= m_nxt;
    ms_r <= ms_nxt;
    pvh_r <= pvh_nxt;
    pvp_r <= pvp_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    cf_r <= cf_nxt;
    cu_r <= cu_nxt;
  end

  ffha_ram #(.WIDTH(MW), .DEPTH(HEAP_UNITS)) u_hdr_ram (
    .clk   (clk),
    .we    (mw_en),
    .waddr (mw_addr),
    .wdata (mw_data),
    .re    (r_en),
    .raddr (r_addr),
    .rdata (m_rd)
  );

  ffha_ram #(.WIDTH(PW), .DEPTH(HEAP_UNITS)) u_prev_ram (
    .clk   (clk),
    .we    (pw_en),
    .waddr (pw_addr),
    .wdata (pw_data),
    .re    (r_en),
    .raddr (r_addr),
    .rdata (p_rd)
  );

  assign out_valid          = (state_r == S_DONE);
  assign out_status         = st_r;
  assign out_result_address = res_r;
  assign out_copy_from      = cf_r;
  assign out_copy_units     = cu_r;
  assign out_free_bytes     = fbc_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_error_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ffha_pkg::ST_OK) |->
      (out_result_address == '0 && out_copy_from == '0 && out_copy_units == '0))
    else $error("error answer carries a block");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mw_en && !pw_en))
    else $error("table written while idle");

endmodule
`default_nettype wire
